FILE: rtl/core/rgb2hsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Payload types, fixed-point constants and the single-bit division step shared
// by the hue and saturation dividers.
// ----------------------------------------------------------------------------
package rgb2hsl_pkg;

    // Field widths of the input pixel and the result.
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned HUE_W   = 15;
    localparam int unsigned SAT_W   = 14;
    localparam int unsigned LIGHT_W = 9;

    // Hue scale: 60 degrees times 64 per sextant, 360 degrees times 64 per turn.
    localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

    // Saturation scale: 255 times 64.
    localparam logic [SAT_W-1:0] SAT_MAX = 14'd16320;

    // Divider geometry. The dividend is 24 bits, the divisor at most 510,
    // and the quotient always fits in 15 bits.
    localparam int unsigned DIV_X_W   = 24;
    localparam int unsigned DIV_Q_W   = 15;
    localparam int unsigned DIV_R_W   = DIV_X_W - DIV_Q_W;
    localparam int unsigned DIV_STEPS = DIV_Q_W;

    // Pipeline: front end, sextant prep, dividend setup, one register per
    // quotient bit, and the output register.
    localparam int unsigned NUM_STAGES = DIV_STEPS + 4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   saturation;
        logic [LIGHT_W-1:0] lightness;
    } hsl_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    // Partial remainder and the word that shifts dividend bits out and
    // quotient bits in.
    typedef struct packed {
        logic [DIV_R_W-1:0] rem;
        logic [DIV_Q_W-1:0] work;
    } div_st_t;

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor if it fits.
    function automatic div_st_t div_step(div_st_t st, logic [DIV_R_W-1:0] y);
        logic [DIV_R_W:0] trial;
        logic [DIV_R_W:0] diff;
        div_st_t          res;
        trial = {st.rem, st.work[DIV_Q_W-1]};
        diff  = trial - {1'b0, y};
        if (trial >= {1'b0, y}) begin
            res.rem  = diff[DIV_R_W-1:0];
            res.work = {st.work[DIV_Q_W-2:0], 1'b1};
        end else begin
            res.rem  = trial[DIV_R_W-1:0];
            res.work = {st.work[DIV_Q_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per cycle into hue, saturation and lightness
// in the hexcone model, with round-to-nearest fixed-point results.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                      Payload
//   -------   ------------------------   ----------------------------------
//   input     s_valid, s_ready, s_data   pixel_t: red, green, blue
//   result    m_valid, m_ready, m_data   hsl_t: hue, saturation, lightness
//
// One transfer is taken in every cycle while the result side keeps up.
// The depth comes from the two 15-bit quotients, formed one bit per stage.
// Reset (aresetn, synchronous, active low) empties the pipeline.
// A stall on the result side holds only the stages behind a full stage, so
// empty stages keep filling and s_ready stays high until the pipeline is full.
//
module rgb_to_hsl_converter
    import rgb2hsl_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,

    input  logic   s_valid,
    output logic   s_ready,
    input  pixel_t s_data,

    output logic   m_valid,
    input  logic   m_ready,
    output hsl_t   m_data
);

    // Stage numbering: 0 front end, 1 sextant prep, 2 dividend setup,
    // 3 through 17 quotient bits, 18 output register.
    localparam int unsigned ST_FRONT = 0;
    localparam int unsigned ST_PREP  = 1;
    localparam int unsigned ST_DIV0  = 2;
    localparam int unsigned ST_OUT   = NUM_STAGES - 1;

    // ------------------------------------------------------------------------
    // Flow control. Each stage loads when it is empty or when the stage after
    // it loads, so bubbles are squeezed out during a stall.
    // ------------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES:0]   stage_en;

    assign stage_en[NUM_STAGES] = m_ready;

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_en
        assign stage_en[i] = !valid_reg[i] || stage_en[i+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[ST_FRONT]) begin
                valid_reg[ST_FRONT] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = stage_en[ST_FRONT];
    assign m_valid = valid_reg[ST_OUT];

    // ------------------------------------------------------------------------
    // Stage 0: largest and smallest channel, which channel leads (red wins
    // ties over green, green over blue), and the signed difference of the
    // other two channels that places the hue inside its sextant.
    // ------------------------------------------------------------------------
    logic [CHAN_W-1:0]  mx_next, mn_next;
    logic [CHAN_W:0]    diff_next;
    chan_t              sel_next;

    logic [LIGHT_W-1:0] f_sum_reg;
    logic [CHAN_W-1:0]  f_d_reg;
    logic [CHAN_W:0]    f_diff_reg;
    chan_t              f_sel_reg;

    always_comb begin
        mx_next = s_data.red;
        mn_next = s_data.red;
        if (s_data.green > mx_next) mx_next = s_data.green;
        if (s_data.blue  > mx_next) mx_next = s_data.blue;
        if (s_data.green < mn_next) mn_next = s_data.green;
        if (s_data.blue  < mn_next) mn_next = s_data.blue;

        if (s_data.red == mx_next) begin
            sel_next  = CH_RED;
            diff_next = {1'b0, s_data.green} - {1'b0, s_data.blue};
        end else if (s_data.green == mx_next) begin
            sel_next  = CH_GREEN;
            diff_next = {1'b0, s_data.blue} - {1'b0, s_data.red};
        end else begin
            sel_next  = CH_BLUE;
            diff_next = {1'b0, s_data.red} - {1'b0, s_data.green};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_FRONT]) begin
            f_sum_reg  <= {1'b0, mx_next} + {1'b0, mn_next};
            f_d_reg    <= mx_next - mn_next;
            f_diff_reg <= diff_next;
            f_sel_reg  <= sel_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: hue numerator in sextant units, m = k*d + diff, where k is 2
    // for a green lead, 4 for blue, and 0 or 6 for red so that the result is
    // never negative (this is the wrap of a negative red hue by a full turn).
    // The saturation denominator folds around mid lightness.
    // ------------------------------------------------------------------------
    logic [10:0]        kd_next;
    logic [11:0]        m_wide_next;
    logic [LIGHT_W-1:0] den_wide_next;

    logic [10:0]        p_m_reg;
    logic [CHAN_W-1:0]  p_den_reg;
    logic [CHAN_W-1:0]  p_d_reg;
    logic [LIGHT_W-1:0] p_sum_reg;

    always_comb begin
        case (f_sel_reg)
            CH_RED: begin
                kd_next = f_diff_reg[CHAN_W] ?
                          ({1'b0, f_d_reg, 2'b00} + {2'b00, f_d_reg, 1'b0}) : 11'd0;
            end
            CH_GREEN: kd_next = {2'b00, f_d_reg, 1'b0};
            CH_BLUE:  kd_next = {1'b0, f_d_reg, 2'b00};
            default:  kd_next = 11'd0;
        endcase
        m_wide_next   = {1'b0, kd_next} + {{3{f_diff_reg[CHAN_W]}}, f_diff_reg};
        den_wide_next = (f_sum_reg <= 9'd255) ? f_sum_reg : 9'd510 - f_sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PREP]) begin
            p_m_reg   <= m_wide_next[10:0];
            p_den_reg <= den_wide_next[CHAN_W-1:0];
            p_d_reg   <= f_d_reg;
            p_sum_reg <= f_sum_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2 and the quotient stages. Rounding to nearest with ties up is
    // floor((2N + D) / 2D), so each divider sees dividend 2N + D and
    // divisor 2D:
    //   hue:        (7680*m + d) / 2d
    //   saturation: (32640*d + den) / 2den
    // Index 0 of the arrays below is the setup stage; index k holds the state
    // after k quotient bits.
    // ------------------------------------------------------------------------
    logic [DIV_X_W-1:0] xh_next, xs_next;

    div_st_t            hue_div_reg [DIV_STEPS+1];
    div_st_t            sat_div_reg [DIV_STEPS+1];
    logic [DIV_R_W-1:0] hue_y_reg   [DIV_STEPS+1];
    logic [DIV_R_W-1:0] sat_y_reg   [DIV_STEPS+1];
    logic [LIGHT_W-1:0] sum_reg     [DIV_STEPS+1];
    logic               gray_reg    [DIV_STEPS+1];

    always_comb begin
        xh_next = {p_m_reg, 13'd0} - {4'd0, p_m_reg, 9'd0} + {16'd0, p_d_reg};
        xs_next = {1'b0, p_d_reg, 15'd0} - {9'd0, p_d_reg, 7'd0} + {16'd0, p_den_reg};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_DIV0]) begin
            hue_div_reg[0] <= '{rem: xh_next[DIV_X_W-1:DIV_Q_W], work: xh_next[DIV_Q_W-1:0]};
            sat_div_reg[0] <= '{rem: xs_next[DIV_X_W-1:DIV_Q_W], work: xs_next[DIV_Q_W-1:0]};
            hue_y_reg[0]   <= {p_d_reg, 1'b0};
            sat_y_reg[0]   <= {p_den_reg, 1'b0};
            sum_reg[0]     <= p_sum_reg;
            gray_reg[0]    <= (p_d_reg == '0);
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (stage_en[ST_DIV0 + k]) begin
                hue_div_reg[k] <= div_step(hue_div_reg[k-1], hue_y_reg[k-1]);
                sat_div_reg[k] <= div_step(sat_div_reg[k-1], sat_y_reg[k-1]);
                hue_y_reg[k]   <= hue_y_reg[k-1];
                sat_y_reg[k]   <= sat_y_reg[k-1];
                sum_reg[k]     <= sum_reg[k-1];
                gray_reg[k]    <= gray_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register. A red-led hue that rounds up to a full turn wraps to
    // zero, and a gray pixel has no hue and no saturation.
    // ------------------------------------------------------------------------
    logic [HUE_W-1:0] hue_q;
    hsl_t             out_next;
    hsl_t             out_reg;

    always_comb begin
        hue_q = hue_div_reg[DIV_STEPS].work;
        if (gray_reg[DIV_STEPS]) begin
            out_next.hue        = '0;
            out_next.saturation = '0;
        end else begin
            out_next.hue        = (hue_q >= HUE_FULL) ? hue_q - HUE_FULL : hue_q;
            out_next.saturation = sat_div_reg[DIV_STEPS].work[SAT_W-1:0];
        end
        out_next.lightness = sum_reg[DIV_STEPS];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef ASSERT_OFF
    // The hue wrap keeps every result below a full turn.
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hue < HUE_FULL))
        else $error("hue reached a full turn");

    // Saturation never exceeds the full scale, since d never exceeds den.
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.saturation <= SAT_MAX))
        else $error("saturation above full scale");

    // Any chromatic pixel has saturation of at least 64, so zero saturation
    // means a gray pixel, which must also have zero hue.
    a_gray: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.saturation == '0)) |-> (m_data.hue == '0))
        else $error("gray pixel with nonzero hue");

    // The input side may only stall when every stage holds a pixel and the
    // result side is stalled too.
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&valid_reg)))
        else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

FILE: test/tb_rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Sends pixels through the converter under random idling on both channels.
// Each result is checked against an in-bench integer model of the hexcone
// conversion, which rounds to nearest with ties rounded up.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter;
    import rgb2hsl_pkg::*;

    // Cycles without any transfer on either channel before the run is abandoned.
    // The longest legitimate quiet stretch is the long result-side hold-off below.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned LONG_HOLD      = 300;

    // A predicted result together with the pixel that produced it, so that a
    // mismatch report can name the input.
    typedef struct {
        pixel_t px;
        hsl_t   hsl;
    } hsl_pending_t;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    pixel_t s_data;
    logic   m_valid;
    logic   m_ready;
    hsl_t   m_data;

    hsl_pending_t pending_hsl[$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          long_hold_req;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    int unsigned n_pixels;
    int unsigned n_results;
    int unsigned n_errors;

    rgb_to_hsl_converter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Integer model of the conversion. Every quotient is the exact ratio of
    // two integers, rounded once to nearest with ties going up.
    function automatic hsl_t hsl_of_pixel(pixel_t px);
        int   r;
        int   g;
        int   b;
        int   mx;
        int   mn;
        int   d;
        int   sum;
        int   den;
        int   num;
        int   h;
        int   s;
        hsl_t res;
        r   = int'(px.red);
        g   = int'(px.green);
        b   = int'(px.blue);
        mx  = (r > g) ? r : g;
        mx  = (b > mx) ? b : mx;
        mn  = (r < g) ? r : g;
        mn  = (b < mn) ? b : mn;
        d   = mx - mn;
        sum = mx + mn;
        h   = 0;
        s   = 0;
        if (d != 0) begin
            // The divisor flips to 510 - sum in the upper half of lightness.
            den = (sum <= 255) ? sum : 510 - sum;
            s   = (2 * 16320 * d + den) / (2 * den);
            // The largest channel picks the sextant; red wins ties over green,
            // and green over blue.
            if (r == mx) begin
                num = 3840 * (g - b);
            end else if (g == mx) begin
                num = 3840 * (2 * d + b - r);
            end else begin
                num = 3840 * (4 * d + r - g);
            end
            // A red maximum with blue above green lies just below a full turn.
            if (num < 0) begin
                num = num + 23040 * d;
            end
            h = (2 * num + d) / (2 * d);
            if (h >= 23040) begin
                h = h - 23040;
            end
        end
        res.hue        = h[HUE_W-1:0];
        res.saturation = s[SAT_W-1:0];
        res.lightness  = sum[LIGHT_W-1:0];
        return res;
    endfunction

    // Random pixel, weighted toward the cases where the arithmetic turns:
    // grey pixels, tied channels and channels at or near their extremes.
    function automatic pixel_t random_pixel();
        pixel_t      px;
        int unsigned pick;
        logic [7:0]  corner[4];
        corner = '{8'd0, 8'd1, 8'd254, 8'd255};
        px     = pixel_t'(24'($urandom));
        pick   = $urandom_range(99);
        if (pick < 8) begin
            px.green = px.red;
            px.blue  = px.red;
        end else if (pick < 16) begin
            case ($urandom_range(2))
                0: begin
                    px.green = px.red;
                end
                1: begin
                    px.blue = px.green;
                end
                default: begin
                    px.blue = px.red;
                end
            endcase
        end else if (pick < 30) begin
            if ($urandom_range(1)) px.red   = corner[2'($urandom_range(3))];
            if ($urandom_range(1)) px.green = corner[2'($urandom_range(3))];
            if ($urandom_range(1)) px.blue  = corner[2'($urandom_range(3))];
        end
        return px;
    endfunction

    // Offers one pixel and returns once it has been taken. An idle gap, if the
    // sender rolls one, comes first, so that valid is only lowered in a cycle
    // where no pixel follows directly.
    task automatic send_pixel(pixel_t px);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        // Right after the edge the ports still hold their values from before
        // it, so this sees the handshake exactly as the block did.
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_hsl.push_back('{px: px, hsl: hsl_of_pixel(px)});
        n_pixels++;
    endtask

    task automatic send_rgb(int unsigned r, int unsigned g, int unsigned b);
        pixel_t px;
        px.red   = r[7:0];
        px.green = g[7:0];
        px.blue  = b[7:0];
        send_pixel(px);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_hsl.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic check_result(hsl_t got);
        hsl_pending_t want;
        if (pending_hsl.size() == 0) begin
            $error("result with nothing pending: hue %0d saturation %0d lightness %0d",
                   got.hue, got.saturation, got.lightness);
            n_errors++;
        end else begin
            want = pending_hsl.pop_front();
            if (got.hue !== want.hsl.hue) begin
                $error("hue: expected %0d, actual %0d (rgb %0d %0d %0d)",
                       want.hsl.hue, got.hue, want.px.red, want.px.green, want.px.blue);
                n_errors++;
            end
            if (got.saturation !== want.hsl.saturation) begin
                $error("saturation: expected %0d, actual %0d (rgb %0d %0d %0d)",
                       want.hsl.saturation, got.saturation,
                       want.px.red, want.px.green, want.px.blue);
                n_errors++;
            end
            if (got.lightness !== want.hsl.lightness) begin
                $error("lightness: expected %0d, actual %0d (rgb %0d %0d %0d)",
                       want.hsl.lightness, got.lightness,
                       want.px.red, want.px.green, want.px.blue);
                n_errors++;
            end
        end
        n_results++;
    endtask

    // Result side: checks each transfer and then decides whether to take the
    // next one. A long hold-off, once requested, is counted down here.
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result(m_data);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Corners of the colour cube, the grey axis, every tie between maximum
    // channels, hue just below a full turn, and both sides of the lightness
    // midpoint where the saturation divisor changes.
    task automatic test_directed();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_rgb(0, 0, 0);
        send_rgb(255, 255, 255);
        send_rgb(128, 128, 128);
        send_rgb(255, 0, 0);
        send_rgb(0, 255, 0);
        send_rgb(0, 0, 255);
        send_rgb(255, 255, 0);
        send_rgb(0, 255, 255);
        send_rgb(255, 0, 255);
        send_rgb(200, 200, 10);
        send_rgb(10, 200, 200);
        send_rgb(200, 10, 200);
        send_rgb(255, 0, 1);
        send_rgb(255, 254, 255);
        send_rgb(1, 0, 0);
        send_rgb(255, 0, 128);
        send_rgb(255, 1, 128);
        send_rgb(128, 0, 127);
        send_rgb(129, 127, 128);
        send_rgb(254, 1, 100);
        send_rgb(3, 1, 2);
        send_rgb(170, 85, 0);
        end_burst();
        wait_drained();
    endtask

    // The result side holds off for a long stretch while pixels keep coming,
    // so the pipeline fills and the input stalls.
    task automatic test_full_pipeline();
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b1;
        repeat (60) send_pixel(random_pixel());
        end_burst();
        wait_drained();
    endtask

    // The sender pauses until every result is out, then resumes.
    task automatic test_drain_pause();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        repeat (20) send_pixel(random_pixel());
        end_burst();
        wait_drained();
        repeat (20) send_pixel(random_pixel());
        end_burst();
        wait_drained();
    endtask

    task automatic test_random(int unsigned tx_pct, int unsigned rx_pct, int unsigned count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_pixel(random_pixel());
        end_burst();
        wait_drained();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        long_hold_req = 1'b0;
        n_pixels      = 0;
        n_results     = 0;
        n_errors      = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_pipeline();
        test_drain_pause();
        test_random(32, 65, 360);
        test_random(65, 32, 360);
        test_random(0, 0, 360);

        // Let anything stray come out of the pipeline before the verdict.
        repeat (NUM_STAGES + 8) @(posedge aclk);
        if (pending_hsl.size() != 0) begin
            $error("%0d results never arrived", pending_hsl.size());
            n_errors++;
        end

        $display("Converted %0d pixels (%0d results checked): cube corners, ties, a full",
                 n_pixels, n_results);
        $display("pipeline under a long output hold-off, a drain pause and three idling mixes.");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rgb2hsl_pkg.sv
rtl/core/rgb_to_hsl_converter.sv
test/tb_rgb_to_hsl_converter.sv
